[rtl/core/fbc64_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fbc64_pkg;

  // Datapath widths
  localparam int unsigned BlockW = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned KeyW   = 64;

  // Round function constants
  localparam int unsigned MixRotL = 9;
  localparam int unsigned KeyShr  = 11;
  localparam int unsigned KeyStep = 3;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_CIPHER_KEY   = 1'b0,
    CFG_DECRYPT_MODE = 1'b1
  } cfg_idx_e;

  typedef logic [HalfW-1:0] half_t;

  // F(x,k) = rotl(x,9) ^ ~((k >> 11) & x)
  function automatic half_t mix(input half_t x, input half_t k);
    half_t rot;
    half_t ks;
    begin
      rot = (x << MixRotL) | (x >> (HalfW - MixRotL));
      ks  = k >> KeyShr;
      mix = rot ^ ~(ks & x);
    end
  endfunction

endpackage

`default_nettype wire

[rtl/core/fbc64_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

// One Feistel round followed by a pipeline register with its own handshake.
module fbc64_stage (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                ready_o,
  input  fbc64_pkg::half_t    left_i,
  input  fbc64_pkg::half_t    right_i,
  input  fbc64_pkg::half_t    key_i,
  output logic                valid_o,
  input  wire                 ready_i,
  output fbc64_pkg::half_t    left_o,
  output fbc64_pkg::half_t    right_o
);
  import fbc64_pkg::*;

  logic  valid_q;
  half_t left_d, left_q;
  half_t right_d, right_q;

  // Stage takes a new item when empty or when its item leaves this cycle
  assign ready_o = !valid_q || ready_i;

  // Round: left <- right, right <- left ^ F(right, key)
  assign left_d  = right_i;
  assign right_d = left_i ^ mix(right_i, key_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign valid_o = valid_q;
  assign left_o  = left_q;
  assign right_o = right_q;

endmodule

`default_nettype wire

[rtl/core/feistel_block_cipher_64_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// One round per stage, each stage registered.
// Throughput: one item per cycle while the output accepts; each stage holds
// one item and moves when the stage after it is empty or advancing, so stalls
// back up without loss. Reset (async, active low) empties the pipeline and
// clears the cipher key and decrypt_mode to zero.
module feistel_block_cipher_64_top #(
  parameter int unsigned ROUNDS = 8
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  // Configuration write port
  input  wire                       cfg_we_i,
  input  fbc64_pkg::cfg_idx_e       cfg_idx_i,
  input  wire [63:0]                cfg_data_i,
  // Input stream
  input  wire                       s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire [63:0]                s_axis_tdata,   // [63:0] data_block
  // Output stream
  output logic                      m_axis_tvalid,
  input  wire                       m_axis_tready,
  output logic [63:0]               m_axis_tdata    // [63:0] result_block
);
  import fbc64_pkg::*;

  localparam int unsigned CntW = $clog2(ROUNDS + 2);

  logic [KeyW-1:0]   cipher_key_q;
  logic              decrypt_mode_q;
  logic [2*KeyW-1:0] key_dbl;

  logic  valid [ROUNDS+1];
  logic  ready [ROUNDS+1];
  half_t left  [ROUNDS+1];
  half_t right [ROUNDS+1];
  logic [ROUNDS-1:0] stage_valid;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cipher_key_q   <= '0;
      decrypt_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CIPHER_KEY:   cipher_key_q   <= cfg_data_i;
        CFG_DECRYPT_MODE: decrypt_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign key_dbl = {cipher_key_q, cipher_key_q};

  // Pipeline entry: left half is the high half in both directions
  assign valid[0]      = s_axis_tvalid;
  assign s_axis_tready = ready[0];
  assign left[0]       = s_axis_tdata[BlockW-1:HalfW];
  assign right[0]      = s_axis_tdata[HalfW-1:0];

  // Round stages; decryption walks the round keys in reverse
  for (genvar s = 0; s < ROUNDS; s++) begin : g_round
    localparam int unsigned RotEnc = (KeyStep * s) % KeyW;
    localparam int unsigned RotDec = (KeyStep * (ROUNDS - 1 - s)) % KeyW;
    half_t key;

    assign key = decrypt_mode_q ? key_dbl[RotDec +: HalfW] : key_dbl[RotEnc +: HalfW];

    fbc64_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[s]),
      .ready_o (ready[s]),
      .left_i  (left[s]),
      .right_i (right[s]),
      .key_i   (key),
      .valid_o (valid[s+1]),
      .ready_i (ready[s+1]),
      .left_o  (left[s+1]),
      .right_o (right[s+1])
    );

    assign stage_valid[s] = valid[s+1];
  end

  // Pipeline exit: halves swap back
  assign ready[ROUNDS]  = m_axis_tready;
  assign m_axis_tvalid  = valid[ROUNDS];
  assign m_axis_tdata   = {right[ROUNDS], left[ROUNDS]};

  // Input only stalls when something is waiting at the output
  a_stall_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // An empty pipeline always takes input
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid == '0) |-> s_axis_tready)
    else $error("empty pipeline not ready");

  // Items in flight change only by accepts on either side
  a_item_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (CntW'($countones(stage_valid))
              + CntW'($past(m_axis_tvalid && m_axis_tready)))
          == (CntW'($past($countones(stage_valid)))
              + CntW'($past(s_axis_tvalid && s_axis_tready))))
    else $error("item lost or duplicated in pipeline");

endmodule

`default_nettype wire

[tb/sv/feistel_checker.sv]
`timescale 1ns / 1ps

// Watches the config port and both streams, predicts each enciphered or
// deciphered block and compares it with what leaves the block.
module feistel_checker #(
  parameter int unsigned ROUNDS = 8
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  fbc64_pkg::cfg_idx_e cfg_idx_i,
  input  wire [63:0]          cfg_data_i,
  input  wire                 blk_valid_i,
  input  wire                 blk_ready_i,
  input  wire [63:0]          blk_data_i,   // [63:0] data_block
  input  wire                 res_valid_i,
  input  wire                 res_ready_i,
  input  wire [63:0]          res_data_i,   // [63:0] result_block
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);
  import fbc64_pkg::*;

  localparam int unsigned MixRot   = 9;
  localparam int unsigned KeyShift = 11;
  localparam int unsigned RotStep  = 3;

  logic [63:0] result_fifo [$];
  logic [63:0] key_q;
  logic        decrypt_q;
  logic [63:0] want;
  int unsigned fails;

  // Round key: low half of the cipher key rotated right by 3 per round
  function automatic logic [31:0] round_key(input logic [63:0] key, input int unsigned idx);
    int unsigned amt;
    logic [63:0] rot;
    amt = (RotStep * idx) % 64;
    if (amt == 0) begin
      rot = key;
    end else begin
      rot = (key >> amt) | (key << (64 - amt));
    end
    return rot[31:0];
  endfunction

  // Round function on one half
  function automatic logic [31:0] round_mix(input logic [31:0] x, input logic [31:0] k);
    logic [31:0] spun;
    spun = (x << MixRot) | (x >> (32 - MixRot));
    return spun ^ ~((k >> KeyShift) & x);
  endfunction

  function automatic logic [63:0] cipher_block(input logic [63:0] blk, input logic [63:0] key,
                                               input logic decrypt);
    logic [31:0] left;
    logic [31:0] right;
    logic [31:0] tmp;
    int r;
    if (!decrypt) begin
      left  = blk[63:32];
      right = blk[31:0];
      for (r = 0; r < ROUNDS; r++) begin
        tmp   = right;
        right = left ^ round_mix(right, round_key(key, r));
        left  = tmp;
      end
      return {right, left};
    end else begin
      left  = blk[31:0];
      right = blk[63:32];
      for (r = ROUNDS - 1; r >= 0; r--) begin
        tmp   = left;
        left  = right ^ round_mix(left, round_key(key, r));
        right = tmp;
      end
      return {left, right};
    end
  endfunction

  // Track config, queue predictions, check results in order
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      decrypt_q <= 1'b0;
      result_fifo.delete();
      fails        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CIPHER_KEY:   key_q <= cfg_data_i;
          CFG_DECRYPT_MODE: decrypt_q <= cfg_data_i[0];  // only bit 0 is kept
          default: ;
        endcase
      end
      if (blk_valid_i && blk_ready_i) begin
        result_fifo.push_back(cipher_block(blk_data_i, key_q, decrypt_q));
      end
      if (res_valid_i && res_ready_i) begin
        if (result_fifo.size() == 0) begin
          $error("result_block: no item expected, actual %h", res_data_i);
          fails++;
        end else begin
          want = result_fifo.pop_front();
          if (want !== res_data_i) begin
            $error("result_block: expected %h, actual %h", want, res_data_i);
            fails++;
          end
        end
      end
      fail_count_o <= fails;
      pending_o    <= result_fifo.size();
    end
  end

endmodule

[tb/sv/tb_feistel_block_cipher_64_top.sv]
`timescale 1ns / 1ps

module tb_feistel_block_cipher_64_top;
  import fbc64_pkg::*;

  localparam int unsigned ROUNDS        = 8;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned HoldAt        = 450;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned RandPhases    = 10;
  localparam int unsigned PhaseItems    = 103;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        cfg_we     = 1'b0;
  cfg_idx_e    cfg_idx    = CFG_CIPHER_KEY;
  logic [63:0] cfg_data   = '0;
  logic        s_tvalid   = 1'b0;
  logic [63:0] s_tdata    = '0;
  logic        m_tready   = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [63:0] m_tdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned blocks_sent = 0;
  logic        sink_holding = 1'b0;

  logic [63:0] corner_blocks [0:7] = '{
    64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
    64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000,
    64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF,
    64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555
  };

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  feistel_block_cipher_64_top #(.ROUNDS(ROUNDS)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  feistel_checker #(.ROUNDS(ROUNDS)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .blk_valid_i  (s_tvalid),
    .blk_ready_i  (s_tready),
    .blk_data_i   (s_tdata),
    .res_valid_i  (m_tvalid),
    .res_ready_i  (m_tready),
    .res_data_i   (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Register write, then cfg_we is dropped before the task returns
  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_cipher(input logic [63:0] key, input logic [63:0] mode_word);
    write_reg(CFG_CIPHER_KEY, key);
    write_reg(CFG_DECRYPT_MODE, mode_word);
  endtask

  // Offer one block after a random or zero gap; returns once it is taken
  task automatic send_block(input logic [63:0] blk);
    int unsigned gap;
    gap = (sink_holding || ((blocks_sent / 40) % 4 == 3)) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= blk;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    blocks_sent++;
  endtask

  // Stop offering and wait until every predicted block has come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (ROUNDS + 2) @(posedge clk_i);
  endtask

  // Result sink: random stalls, zero-stall stretches, one long hold-off
  initial begin
    int unsigned taken;
    int unsigned gap;
    taken = 0;
    forever begin
      if (taken == HoldAt) begin
        m_tready     <= 1'b0;
        sink_holding = 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        sink_holding = 1'b0;
      end else begin
        gap = ((taken / 50) % 3 == 2) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
      taken++;
    end
  end

  // Watchdog on cycles with no item moving
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int unsigned p;
    int unsigned n;
    logic [63:0] key;
    logic [63:0] mode_word;
    logic [63:0] blk;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corner blocks under reset config: zero key, encrypt
    for (n = 0; n < 8; n++) send_block(corner_blocks[n]);
    drain_results();

    // All-ones key, decrypt written with every upper bit set
    set_cipher(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    for (n = 0; n < 8; n++) send_block(corner_blocks[n]);
    drain_results();

    // Distinct key halves so round 0 uses the unrotated low half; encrypt
    // written with upper bits set and bit 0 clear
    set_cipher(64'h0123_4567_89AB_CDEF, 64'hFFFF_FFFF_FFFF_FFFE);
    for (n = 0; n < 8; n++) send_block(corner_blocks[n]);
    drain_results();

    // Random phases, each under its own key and direction
    for (p = 0; p < RandPhases; p++) begin
      if (p == 0) begin
        key       = '0;
        mode_word = 64'd1;
      end else if (p == 1) begin
        key       = '1;
        mode_word = 64'd0;
      end else begin
        key       = {$urandom, $urandom};
        mode_word = {$urandom, $urandom};
      end
      set_cipher(key, mode_word);
      for (n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 15) == 0) begin
          blk = corner_blocks[$urandom_range(0, 7)];
        end else begin
          blk = {$urandom, $urandom};
        end
        send_block(blk);
      end
      drain_results();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[feistel_block_cipher_64_top.f]
rtl/core/fbc64_pkg.sv
rtl/core/fbc64_stage.sv
rtl/core/feistel_block_cipher_64_top.sv
tb/sv/feistel_checker.sv
tb/sv/tb_feistel_block_cipher_64_top.sv
